### rtl/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants of the bit field reader: command codes, status
// codes, channel payloads and the widths of the field datapath.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int FIELD_W = 56;
  localparam int WIN_W   = 64;
  localparam int FAMT_W  = 6;

  typedef enum logic [2:0] {
    MODE_RESTART    = 3'd0,
    MODE_LOAD       = 3'd1,
    MODE_READ       = 3'd2,
    MODE_SKIP       = 3'd3,
    MODE_ALIGN      = 3'd4,
    MODE_SEEK_START = 3'd5,
    MODE_SEEK_CUR   = 3'd6,
    MODE_SEEK_END   = 3'd7
  } bfr_mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_BAD   = 2'd2
  } bfr_status_t;

  typedef struct packed {
    bfr_mode_t   mode;
    logic [7:0]  byte_value;
    logic [15:0] amount;
  } bfr_cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] field_value;
    logic [1:0]         status;
    logic [15:0]        position_bits;
    logic [15:0]        remaining_bits;
  } bfr_rsp_t;

  typedef struct packed {
    logic byte_order;
  } bfr_cfg_t;

endpackage

### rtl/bfr_stream_if.sv
// ----------------------------------------------------------------------------
// bfr_stream_if
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface bfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/bfr_ram.sv
// ----------------------------------------------------------------------------
// bfr_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bfr_field_extract.sv
// ----------------------------------------------------------------------------
// bfr_field_extract
// Cuts a right-justified field out of a window of up to eight fetched bytes,
// in either bit order, and registers it.
// ----------------------------------------------------------------------------
module bfr_field_extract (
  input  logic                        clk,
  input  logic [bfr_pkg::WIN_W-1:0]   window,
  input  logic [2:0]                  sub,
  input  logic [bfr_pkg::FAMT_W-1:0]  amount,
  input  logic                        byte_order,
  output logic [bfr_pkg::FIELD_W-1:0] value
);

  localparam int SH_W = $clog2(bfr_pkg::WIN_W) + 1;

  logic [bfr_pkg::WIN_W-1:0]   le_shift;
  logic [bfr_pkg::WIN_W-1:0]   be_shift;
  logic [bfr_pkg::WIN_W-1:0]   be_right;
  logic [SH_W-1:0]             be_amt;
  logic [bfr_pkg::FIELD_W-1:0] le_mask;
  logic [bfr_pkg::FIELD_W-1:0] value_next;

  // In little-endian order the window holds the first byte lowest; in
  // big-endian order it holds the first byte highest.
  always_comb begin
    le_shift   = window >> sub;
    le_mask    = ~({bfr_pkg::FIELD_W{1'b1}} << amount);
    be_shift   = window << sub;
    be_amt     = SH_W'(bfr_pkg::WIN_W) - SH_W'(amount);
    be_right   = be_shift >> be_amt;
    value_next = byte_order ? be_right[bfr_pkg::FIELD_W-1:0]
                            : (le_shift[bfr_pkg::FIELD_W-1:0] & le_mask);
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### rtl/bit_field_reader.sv
// ----------------------------------------------------------------------------
// bit_field_reader
// Byte buffer read as a bit stream with an exact bit position.
// ----------------------------------------------------------------------------
// Commands are handled one at a time and each gives one response beat.
// Restart, load, skip, align, seek and every failed or empty read respond
// straight from the execute state. A successful read first fetches the
// bytes that the field spans, one per cycle, because the byte memory has
// one read port, then extracts the field and responds. A finished
// response waits in an
// output register, so the next command is accepted while it is pending. The
// byte memory is not cleared after reset; only loaded bytes are ever read.
// ----------------------------------------------------------------------------
module bit_field_reader #(
  parameter int BUF_BYTES      = 4096,
  parameter int MAX_FIELD_BITS = 56
) (
  input  logic         clk,
  input  logic         rst,
  bfr_stream_if.sink   cmd,
  bfr_stream_if.source rsp,
  bfr_stream_if.sink   cfg
);

  localparam int AW    = $clog2(BUF_BYTES);
  localparam int LEN_W = $clog2(BUF_BYTES + 1);
  localparam int POS_W = LEN_W + 3;
  localparam int SUM_W = ((POS_W > 16) ? POS_W : 16) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_EXTRACT,
    S_DONE
  } state_t;

  state_t                      state;
  logic [LEN_W-1:0]            len;
  logic [POS_W-1:0]            pos;
  logic                        byte_order;
  bfr_pkg::bfr_mode_t          op;
  logic [7:0]                  bval;
  logic [15:0]                 amt;
  logic [3:0]                  iss;
  logic [3:0]                  recv;
  logic [3:0]                  cnt;
  logic [LEN_W-1:0]            start;
  logic [2:0]                  sub;
  logic                        rvalid_q;
  logic [bfr_pkg::WIN_W-1:0]   window;
  logic                        rsp_valid;
  bfr_pkg::bfr_rsp_t           rsp_data;

  logic [POS_W-1:0]            total;
  logic [POS_W-1:0]            rem;
  logic [SUM_W-1:0]            amt_x;
  logic [SUM_W-1:0]            pos_x;
  logic [SUM_W-1:0]            total_x;
  logic [SUM_W-1:0]            len_x;
  logic [SUM_W-1:0]            sum;
  logic [SUM_W-1:0]            byte_sum;
  logic [LEN_W-1:0]            len_next;
  logic [POS_W-1:0]            pos_next;
  logic [POS_W-1:0]            rem_next;
  logic [SUM_W-1:0]            pos_out;
  logic [SUM_W-1:0]            rem_out;
  bfr_pkg::bfr_status_t        st;
  logic [bfr_pkg::FIELD_W-1:0] val;
  logic                        need_fetch;
  logic                        load_ok;
  logic [5:0]                  span;
  logic                        slot_free;
  logic                        commit;
  logic                        issue;
  logic [AW-1:0]               raddr;
  logic [7:0]                  rdata;
  logic [2:0]                  slot;
  logic [bfr_pkg::FIELD_W-1:0] ext_value;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign slot_free = !rsp_valid || rsp.ready;
  assign commit    = slot_free && (((state == S_EXEC) && !need_fetch) || (state == S_DONE));
  assign issue     = (state == S_FETCH) && (iss < cnt);
  assign raddr     = AW'(start + LEN_W'(iss));
  assign slot      = byte_order ? (3'd7 - recv[2:0]) : recv[2:0];
  assign span      = {3'b000, pos[2:0]} + amt[5:0] - 6'd1;

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (commit && (state == S_EXEC) && load_ok),
    .waddr (len[AW-1:0]),
    .wdata (bval),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  bfr_field_extract u_extract (
    .clk        (clk),
    .window     (window),
    .sub        (sub),
    .amount     (amt[bfr_pkg::FAMT_W-1:0]),
    .byte_order (byte_order),
    .value      (ext_value)
  );

  always_comb begin
    total      = {len, 3'b000};
    rem        = total - pos;
    amt_x      = SUM_W'(amt);
    pos_x      = SUM_W'(pos);
    total_x    = SUM_W'(total);
    len_x      = SUM_W'(len);
    sum        = '0;
    byte_sum   = '0;
    len_next   = len;
    pos_next   = pos;
    st         = bfr_pkg::STAT_OK;
    val        = '0;
    need_fetch = 1'b0;
    load_ok    = 1'b0;
    if (state == S_DONE) begin
      pos_next = pos + POS_W'(amt[bfr_pkg::FAMT_W-1:0]);
      val      = ext_value;
    end else begin
      case (op)
        bfr_pkg::MODE_RESTART: begin
          len_next = '0;
          pos_next = '0;
        end
        bfr_pkg::MODE_LOAD: begin
          if (len < LEN_W'(BUF_BYTES)) begin
            load_ok  = 1'b1;
            len_next = len + LEN_W'(1);
          end else begin
            st = bfr_pkg::STAT_BAD;
          end
        end
        bfr_pkg::MODE_READ: begin
          if (amt_x > SUM_W'(MAX_FIELD_BITS)) begin
            st  = bfr_pkg::STAT_BAD;
            val = '1;
          end else if (SUM_W'(rem) < amt_x) begin
            st  = bfr_pkg::STAT_SHORT;
            val = '1;
          end else if (amt != 16'd0) begin
            need_fetch = 1'b1;
          end
        end
        bfr_pkg::MODE_SKIP: begin
          sum      = pos_x + amt_x;
          pos_next = (sum > total_x) ? total : POS_W'(sum);
        end
        bfr_pkg::MODE_ALIGN: begin
          if ((amt == 16'd0) || ((amt & (amt - 16'd1)) != 16'd0)) begin
            st = bfr_pkg::STAT_BAD;
          end else begin
            sum      = (pos_x + amt_x - SUM_W'(1)) & ~(amt_x - SUM_W'(1));
            pos_next = (sum > total_x) ? total : POS_W'(sum);
          end
        end
        bfr_pkg::MODE_SEEK_START: begin
          byte_sum = (amt_x < len_x) ? amt_x : len_x;
          pos_next = {LEN_W'(byte_sum), 3'b000};
        end
        bfr_pkg::MODE_SEEK_CUR: begin
          byte_sum = SUM_W'(pos[POS_W-1:3]) + amt_x;
          if (byte_sum > len_x) begin
            byte_sum = len_x;
          end
          pos_next = {LEN_W'(byte_sum), 3'b000};
        end
        bfr_pkg::MODE_SEEK_END: begin
          pos_next = total;
        end
        default: begin
          pos_next = pos;
        end
      endcase
    end
    rem_next = {len_next, 3'b000} - pos_next;
    pos_out  = SUM_W'(pos_next);
    rem_out  = SUM_W'(rem_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      len        <= '0;
      pos        <= '0;
      byte_order <= 1'b0;
      rsp_valid  <= 1'b0;
      rvalid_q   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        byte_order <= cfg.data.byte_order;
      end
      rvalid_q <= issue;
      if (commit) begin
        len                     <= len_next;
        pos                     <= pos_next;
        rsp_valid               <= 1'b1;
        rsp_data.field_value    <= val;
        rsp_data.status         <= st;
        rsp_data.position_bits  <= pos_out[15:0];
        rsp_data.remaining_bits <= rem_out[15:0];
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op    <= cmd.data.mode;
            bval  <= cmd.data.byte_value;
            amt   <= cmd.data.amount;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (need_fetch) begin
            iss    <= '0;
            recv   <= '0;
            cnt    <= {1'b0, span[5:3]} + 4'd1;
            start  <= pos[POS_W-1:3];
            sub    <= pos[2:0];
            window <= '0;
            state  <= S_FETCH;
          end else if (slot_free) begin
            state <= S_IDLE;
          end
        end
        S_FETCH: begin
          if (issue) begin
            iss <= iss + 4'd1;
          end
          if (rvalid_q) begin
            window[slot*8 +: 8] <= rdata;
            recv                <= recv + 4'd1;
            if ((recv + 4'd1) == cnt) begin
              state <= S_EXTRACT;
            end
          end
        end
        S_EXTRACT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/sv/bit_field_reader_tb.sv
// ----------------------------------------------------------------------------
// bit_field_reader_tb
// Self-checking testbench for the bit field reader. It drives commands on the
// command channel, changes the byte order only while the block is idle and
// predicts every response beat from its own copy of the byte buffer, length,
// bit position and byte order. Directed tests cover the field and amount
// extremes and the error and clamping cases of read, skip, align and seek. A backpressure test and a long random
// phase with stalls on both sides follow.
// ----------------------------------------------------------------------------
module bit_field_reader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          BUF_BYTES      = 4096;
  localparam int          MAX_FIELD_BITS = 56;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned MAX_PRINTS     = 100;

  logic clk;
  logic rst;

  bfr_stream_if #(.payload_t(bfr_pkg::bfr_cmd_t)) cmd_if ();
  bfr_stream_if #(.payload_t(bfr_pkg::bfr_rsp_t)) rsp_if ();
  bfr_stream_if #(.payload_t(bfr_pkg::bfr_cfg_t)) cfg_if ();

  bit_field_reader i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  logic [7:0]        shadow_mem [BUF_BYTES];
  int unsigned       shadow_len;
  int unsigned       shadow_pos;
  logic              shadow_order;
  bfr_pkg::bfr_rsp_t awaited_rsp [$];

  int unsigned err_count;
  int unsigned quiet_cycles;
  int unsigned hold_len;
  bit          send_idling;
  bit          recv_idling;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_gap(bit enabled);
    if (!enabled || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic bfr_pkg::bfr_rsp_t stream_step(bfr_pkg::bfr_cmd_t c);
    bfr_pkg::bfr_rsp_t           r;
    logic [bfr_pkg::FIELD_W-1:0] val;
    bfr_pkg::bfr_status_t        st;
    int unsigned                 amt, total, target, idx, sub, i;
    logic                        bitv;
    val   = '0;
    st    = bfr_pkg::STAT_OK;
    amt   = c.amount;
    total = shadow_len * 8;
    case (c.mode)
      bfr_pkg::MODE_RESTART: begin
        shadow_len = 0;
        shadow_pos = 0;
      end
      bfr_pkg::MODE_LOAD: begin
        if (shadow_len < BUF_BYTES) begin
          shadow_mem[shadow_len] = c.byte_value;
          shadow_len++;
        end else begin
          st = bfr_pkg::STAT_BAD;
        end
      end
      bfr_pkg::MODE_READ: begin
        if (amt > MAX_FIELD_BITS) begin
          st  = bfr_pkg::STAT_BAD;
          val = '1;
        end else if (total - shadow_pos < amt) begin
          st  = bfr_pkg::STAT_SHORT;
          val = '1;
        end else begin
          for (i = 0; i < amt; i++) begin
            idx  = (shadow_pos + i) >> 3;
            sub  = (shadow_pos + i) & 7;
            bitv = shadow_order ? shadow_mem[idx][7 - sub] : shadow_mem[idx][sub];
            if (shadow_order) begin
              val = {val[bfr_pkg::FIELD_W-2:0], bitv};
            end else begin
              val[i] = bitv;
            end
          end
          shadow_pos += amt;
        end
      end
      bfr_pkg::MODE_SKIP: begin
        target     = shadow_pos + amt;
        shadow_pos = (target < total) ? target : total;
      end
      bfr_pkg::MODE_ALIGN: begin
        if (amt == 0 || (amt & (amt - 1)) != 0) begin
          st = bfr_pkg::STAT_BAD;
        end else begin
          target     = (shadow_pos + amt - 1) & ~(amt - 1);
          shadow_pos = (target < total) ? target : total;
        end
      end
      bfr_pkg::MODE_SEEK_START: begin
        target     = (amt < shadow_len) ? amt : shadow_len;
        shadow_pos = target * 8;
      end
      bfr_pkg::MODE_SEEK_CUR: begin
        target     = (shadow_pos >> 3) + amt;
        shadow_pos = ((target > shadow_len) ? shadow_len : target) * 8;
      end
      default: begin
        shadow_pos = total;
      end
    endcase
    total            = shadow_len * 8;
    r.field_value    = val;
    r.status         = st;
    r.position_bits  = 16'(shadow_pos);
    r.remaining_bits = 16'(total - shadow_pos);
    return r;
  endfunction

  task automatic report_error(string what);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("tb: mismatch at %0t: %s", $realtime, what);
    end
  endtask

  // Prediction, response checking and the watchdog all run on the rising edge.
  always @(posedge clk) begin : monitor
    bfr_pkg::bfr_rsp_t got;
    bfr_pkg::bfr_rsp_t want;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        shadow_order = cfg_if.data.byte_order;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        awaited_rsp.push_back(stream_step(cmd_if.data));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (awaited_rsp.size() == 0) begin
          report_error("response beat with no command outstanding");
        end else begin
          want = awaited_rsp.pop_front();
          if (got.field_value !== want.field_value) begin
            report_error($sformatf("field_value %h, predicted %h",
                                   got.field_value, want.field_value));
          end
          if (got.status !== want.status) begin
            report_error($sformatf("status %0d, predicted %0d", got.status, want.status));
          end
          if (got.position_bits !== want.position_bits) begin
            report_error($sformatf("position_bits %0d, predicted %0d",
                                   got.position_bits, want.position_bits));
          end
          if (got.remaining_bits !== want.remaining_bits) begin
            report_error($sformatf("remaining_bits %0d, predicted %0d",
                                   got.remaining_bits, want.remaining_bits));
          end
        end
      end
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Response sink: a random stall before each beat, or a long hold-off on request.
  initial begin : rsp_sink
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_len != 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = draw_gap(recv_idling);
      end
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic issue_cmd(bfr_pkg::bfr_mode_t md, logic [7:0] bval, logic [15:0] amt);
    bfr_pkg::bfr_cmd_t c;
    int unsigned       gap;
    gap          = draw_gap(send_idling);
    c.mode       = md;
    c.byte_value = bval;
    c.amount     = amt;
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    @(negedge clk);
  endtask

  task automatic settle_stream();
    cmd_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_order(logic order);
    bfr_pkg::bfr_cfg_t c;
    settle_stream();
    c.byte_order = order;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_directed();
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd0);
    issue_cmd(bfr_pkg::MODE_READ, 8'hFF, 16'd8);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'hA5, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h3C, 16'hFFFF);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'hFF, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h00, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h81, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h5A, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'hC3, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h7E, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h12, 16'd0);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd3);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd56);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd57);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd16);
    issue_cmd(bfr_pkg::MODE_SKIP, 8'h00, 16'd32768);
    issue_cmd(bfr_pkg::MODE_SEEK_START, 8'h00, 16'd0);
    issue_cmd(bfr_pkg::MODE_ALIGN, 8'h00, 16'd0);
    issue_cmd(bfr_pkg::MODE_ALIGN, 8'h00, 16'd3);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd5);
    issue_cmd(bfr_pkg::MODE_ALIGN, 8'h00, 16'd8);
    issue_cmd(bfr_pkg::MODE_ALIGN, 8'h00, 16'd32768);
    issue_cmd(bfr_pkg::MODE_SEEK_START, 8'h00, 16'd2);
    issue_cmd(bfr_pkg::MODE_SEEK_CUR, 8'h00, 16'd3);
    issue_cmd(bfr_pkg::MODE_SEEK_CUR, 8'h00, 16'd32768);
    issue_cmd(bfr_pkg::MODE_SEEK_START, 8'h00, 16'd32768);
    issue_cmd(bfr_pkg::MODE_SEEK_END, 8'h00, 16'd32768);
    issue_cmd(bfr_pkg::MODE_RESTART, 8'h00, 16'd0);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd1);
  endtask

  task automatic test_byte_order();
    write_order(1'b1);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'hB4, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h69, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'hF0, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h0F, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'hE7, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h18, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'hAA, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'h55, 16'd0);
    issue_cmd(bfr_pkg::MODE_LOAD, 8'hC9, 16'd0);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd1);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd7);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd3);
    write_order(1'b0);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd5);
    write_order(1'b1);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd19);
    issue_cmd(bfr_pkg::MODE_SEEK_START, 8'h00, 16'd1);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd56);
    issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'd9);
  endtask

  task automatic test_backpressure();
    int unsigned n;
    settle_stream();
    send_idling = 1'b0;
    hold_len    = HOLD_CYCLES;
    for (n = 0; n < 24; n++) begin
      if (n % 3 == 2) begin
        issue_cmd(bfr_pkg::MODE_READ, 8'h00, 16'($urandom_range(0, 16)));
      end else begin
        issue_cmd(bfr_pkg::MODE_LOAD, 8'($urandom), 16'd0);
      end
    end
    send_idling = 1'b1;
    settle_stream();
  endtask

  task automatic test_random_stream(int unsigned count);
    int unsigned n, pick, left, cap;
    logic [15:0] amt;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      left = shadow_len * 8 - shadow_pos;
      cap  = (left < MAX_FIELD_BITS) ? left : MAX_FIELD_BITS;
      if (pick < 2) begin
        issue_cmd(bfr_pkg::MODE_RESTART, 8'($urandom), 16'($urandom_range(0, 32768)));
      end else if (pick < 36) begin
        issue_cmd(bfr_pkg::MODE_LOAD, 8'($urandom), 16'($urandom_range(0, 32768)));
      end else if (pick < 66) begin
        if (left != 0 && $urandom_range(0, 4) != 0) begin
          amt = 16'($urandom_range(0, cap));
        end else if ($urandom_range(0, 3) != 0) begin
          amt = 16'($urandom_range(0, 64));
        end else begin
          amt = 16'($urandom_range(0, 32768));
        end
        issue_cmd(bfr_pkg::MODE_READ, 8'($urandom), amt);
      end else if (pick < 74) begin
        amt = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 40))
                                          : 16'($urandom_range(0, 32768));
        issue_cmd(bfr_pkg::MODE_SKIP, 8'($urandom), amt);
      end else if (pick < 82) begin
        amt = ($urandom_range(0, 3) != 0) ? 16'(1 << $urandom_range(0, 15))
                                          : 16'($urandom_range(0, 32768));
        issue_cmd(bfr_pkg::MODE_ALIGN, 8'($urandom), amt);
      end else if (pick < 90) begin
        amt = ($urandom_range(0, 5) != 0) ? 16'($urandom_range(0, shadow_len + 2))
                                          : 16'($urandom_range(0, 32768));
        issue_cmd(bfr_pkg::MODE_SEEK_START, 8'($urandom), amt);
      end else if (pick < 96) begin
        amt = ($urandom_range(0, 5) != 0) ? 16'($urandom_range(0, 6))
                                          : 16'($urandom_range(0, 32768));
        issue_cmd(bfr_pkg::MODE_SEEK_CUR, 8'($urandom), amt);
      end else begin
        issue_cmd(bfr_pkg::MODE_SEEK_END, 8'($urandom), 16'($urandom_range(0, 32768)));
      end
    end
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rst          = 1'b1;
    shadow_len   = 0;
    shadow_pos   = 0;
    shadow_order = 1'b0;
    err_count    = 0;
    quiet_cycles = 0;
    hold_len     = 0;
    send_idling  = 1'b1;
    recv_idling  = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_order(1'b0);
    test_directed();
    test_byte_order();
    test_backpressure();
    write_order(1'b0);
    test_random_stream(220);
    write_order(1'b1);
    test_random_stream(220);
    write_order(1'b0);
    test_random_stream(220);
    write_order(1'b1);
    test_random_stream(220);

    settle_stream();
    repeat (20) @(posedge clk);
    if (err_count == 0 && awaited_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### bit_field_reader.f
rtl/bfr_pkg.sv
rtl/bfr_stream_if.sv
rtl/bfr_ram.sv
rtl/bfr_field_extract.sv
rtl/bit_field_reader.sv
tb/sv/bit_field_reader_tb.sv
